// File: rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the command slot tracker.
// ----------------------------------------------------------------------------
package cst_pkg;

  // operation codes carried on the command word
  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_INTR    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_WAIT    = 2'd3
  } op_e;

  // fixed field widths
  localparam int unsigned MASK_W     = 32;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned SLOT_CNT_W = 6;

  // slot count after reset
  localparam logic [SLOT_CNT_W-1:0] SLOT_CNT_RST = 6'd32;

  // planes of one port entry
  localparam int unsigned ENT_ISS  = 0;
  localparam int unsigned ENT_DONE = 1;
  localparam int unsigned ENT_ERR  = 2;
  localparam int unsigned ENT_WAIT = 3;

endpackage

// File: rtl/command_slot_tracker.sv
// ----------------------------------------------------------------------------
// command_slot_tracker
// Per-port command slot tracker: reserve, interrupt completion, polled
// release and wait, over per-port issued/done/error/waiter masks.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  command  | in_valid_i / in_stall_o   | opcode, port, slot, sact, ci, tfe
//  result   | out_valid_o / out_stall_i | ok, slot_index, masks, flags
//  config   | cfg_we_i                  | cfg_data_i (slot count)
//
// One word per cycle sustained while the output is not stalled; the memory
// is read into the stage-1 register on the edge that takes a command word,
// then the entry is modified, written back and registered into the output. A
// forwarding register carries a written entry to a word for the same port
// taken in the same cycle. Reset needs no sweep:
// a valid bit per port makes an unwritten entry read as all zero.
// An output stall holds the result and backs up into the command channel.
module command_slot_tracker #(
  parameter int unsigned PORTS = 32,
  parameter int unsigned SLOTS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [cst_pkg::SLOT_CNT_W-1:0]        cfg_data_i,
  // command channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            opcode_i,
  input  logic [4:0]                            port_i,
  input  logic [4:0]                            slot_i,
  input  logic [cst_pkg::MASK_W-1:0]            sact_bits_i,
  input  logic [cst_pkg::MASK_W-1:0]            ci_bits_i,
  input  logic                                  task_error_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  ok_o,
  output logic [cst_pkg::IDX_W-1:0]             slot_index_o,
  output logic [cst_pkg::MASK_W-1:0]            completed_mask_o,
  output logic [cst_pkg::MASK_W-1:0]            wake_mask_o,
  output logic                                  done_res_o,
  output logic                                  failed_o,
  output logic                                  blocked_o
);

  localparam int unsigned PW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam logic [5:0] PortsLim = 6'(PORTS);
  localparam logic [5:0] SlotsLim = 6'(SLOTS);

  typedef logic [3:0][SLOTS-1:0] entry_t;

  // configuration
  logic [cst_pkg::SLOT_CNT_W-1:0] slot_cnt_q;

  // port state memory and valid bits
  entry_t             mem_q [PORTS];
  entry_t             rdata_q;
  logic [PORTS-1:0]   vld_q, vld_d;
  logic               rd_vld_q;

  // forwarding
  logic               fwd_sel_q;
  entry_t             fwd_q;

  // stage 1 (entry read in flight)
  logic                         s1_valid_q;
  cst_pkg::op_e                 s1_op_q;
  logic [4:0]                   s1_port_q;
  logic [4:0]                   s1_slot_q;
  logic                         s1_port_ok_q;
  logic                         s1_slot_ok_q;
  logic [cst_pkg::MASK_W-1:0]   s1_sact_q;
  logic [cst_pkg::MASK_W-1:0]   s1_ci_q;
  logic                         s1_tfe_q;

  // output register
  logic                         out_valid_q;
  logic                         ok_q, ok_d;
  logic [cst_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [cst_pkg::MASK_W-1:0]   comp_q, comp_d;
  logic [cst_pkg::MASK_W-1:0]   wake_q, wake_d;
  logic                         dn_q, dn_d;
  logic                         fl_q, fl_d;
  logic                         blk_q, blk_d;

  // control
  logic               in_acc;
  logic               s1_adv;
  logic               in_port_ok;
  logic               in_slot_ok;
  logic               fwd_hit;
  logic [PW-1:0]      rd_addr;
  logic [PW-1:0]      wr_addr;

  // modify datapath
  entry_t             cur;
  entry_t             nxt;
  logic [5:0]         limit;
  logic [SLOTS-1:0]   lim_mask;
  logic [SLOTS-1:0]   busy;
  logic [SLOTS-1:0]   free;
  logic [SLOTS-1:0]   grant;
  logic [cst_pkg::IDX_W-1:0] grant_idx;
  logic [SLOTS-1:0]   comp;
  logic [SLOTS-1:0]   sbit;

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_port_ok = {1'b0, port_i} < PortsLim;
  assign in_slot_ok = {1'b0, slot_i} < SlotsLim;
  assign rd_addr    = port_i[PW-1:0];
  assign wr_addr    = s1_port_q[PW-1:0];
  assign fwd_hit    = s1_adv && s1_port_ok_q && in_port_ok && (port_i == s1_port_q);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_cnt_q <= cst_pkg::SLOT_CNT_RST;
    end else if (cfg_we_i) begin
      slot_cnt_q <= cfg_data_i;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_port_ok_q) begin
      mem_q[wr_addr] <= nxt;
    end
    if (in_acc) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // mark entries written
  always_comb begin
    vld_d = vld_q;
    if (s1_adv && s1_port_ok_q) begin
      vld_d[wr_addr] = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      fwd_sel_q   <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      out_valid_q <= s1_adv || (out_valid_q && out_stall_i);
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        rd_vld_q   <= vld_q[rd_addr];
        fwd_sel_q  <= fwd_hit;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // capture command word and forwarded entry
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q      <= cst_pkg::op_e'(opcode_i);
      s1_port_q    <= port_i;
      s1_slot_q    <= slot_i;
      s1_port_ok_q <= in_port_ok;
      s1_slot_ok_q <= in_slot_ok;
      s1_sact_q    <= sact_bits_i;
      s1_ci_q      <= ci_bits_i;
      s1_tfe_q     <= task_error_i;
      fwd_q        <= nxt;
    end
  end

  // pick the current entry
  assign cur = fwd_sel_q ? fwd_q : (rd_vld_q ? rdata_q : '0);

  // slot window, lowest free slot, slot decode
  always_comb begin
    limit = (slot_cnt_q > SlotsLim) ? SlotsLim : slot_cnt_q;
    for (int i = 0; i < SLOTS; i++) begin
      lim_mask[i] = 6'(i) < limit;
      sbit[i]     = s1_slot_q == 5'(i);
    end
    busy  = s1_sact_q[SLOTS-1:0] | s1_ci_q[SLOTS-1:0] | cur[cst_pkg::ENT_ISS];
    free  = ~busy & lim_mask;
    grant = free & (~free + SLOTS'(1));
    grant_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (grant[i]) begin
        grant_idx = grant_idx | 5'(i);
      end
    end
    comp = cur[cst_pkg::ENT_ISS] & ~s1_ci_q[SLOTS-1:0];
  end

  // modify the entry and form the result
  always_comb begin
    nxt    = cur;
    ok_d   = 1'b0;
    idx_d  = '0;
    comp_d = '0;
    wake_d = '0;
    dn_d   = 1'b0;
    fl_d   = 1'b0;
    blk_d  = 1'b0;
    if (s1_port_ok_q) begin
      case (s1_op_q)
        cst_pkg::OP_RESERVE: begin
          nxt[cst_pkg::ENT_ISS]  = cur[cst_pkg::ENT_ISS] | grant;
          nxt[cst_pkg::ENT_DONE] = cur[cst_pkg::ENT_DONE] & ~grant;
          nxt[cst_pkg::ENT_ERR]  = cur[cst_pkg::ENT_ERR] & ~grant;
          nxt[cst_pkg::ENT_WAIT] = cur[cst_pkg::ENT_WAIT] & ~grant;
          ok_d  = |grant;
          idx_d = grant_idx;
        end
        cst_pkg::OP_INTR: begin
          nxt[cst_pkg::ENT_ISS]  = cur[cst_pkg::ENT_ISS] & ~comp;
          nxt[cst_pkg::ENT_DONE] = cur[cst_pkg::ENT_DONE] | comp;
          nxt[cst_pkg::ENT_ERR]  = s1_tfe_q ? (cur[cst_pkg::ENT_ERR] | comp)
                                            : (cur[cst_pkg::ENT_ERR] & ~comp);
          nxt[cst_pkg::ENT_WAIT] = cur[cst_pkg::ENT_WAIT] & ~comp;
          comp_d = cst_pkg::MASK_W'(comp);
          wake_d = cst_pkg::MASK_W'(cur[cst_pkg::ENT_WAIT] & comp);
          fl_d   = (|comp) && s1_tfe_q;
        end
        cst_pkg::OP_RELEASE: begin
          // busy slot without error: leave it for the next poll
          if (s1_slot_ok_q) begin
            if (!(|(s1_ci_q[SLOTS-1:0] & sbit))) begin
              nxt[cst_pkg::ENT_ISS] = cur[cst_pkg::ENT_ISS] & ~sbit;
              dn_d = 1'b1;
            end else if (s1_tfe_q) begin
              nxt[cst_pkg::ENT_ISS] = cur[cst_pkg::ENT_ISS] & ~sbit;
              fl_d = 1'b1;
            end
          end
        end
        cst_pkg::OP_WAIT: begin
          if (s1_slot_ok_q) begin
            if (|(cur[cst_pkg::ENT_DONE] & sbit)) begin
              dn_d = 1'b1;
              fl_d = |(cur[cst_pkg::ENT_ERR] & sbit);
            end else begin
              nxt[cst_pkg::ENT_WAIT] = cur[cst_pkg::ENT_WAIT] | sbit;
              blk_d = 1'b1;
            end
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ok_q   <= ok_d;
      idx_q  <= idx_d;
      comp_q <= comp_d;
      wake_q <= wake_d;
      dn_q   <= dn_d;
      fl_q   <= fl_d;
      blk_q  <= blk_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = ok_q;
  assign slot_index_o     = idx_q;
  assign completed_mask_o = comp_q;
  assign wake_mask_o      = wake_q;
  assign done_res_o       = dn_q;
  assign failed_o         = fl_q;
  assign blocked_o        = blk_q;

endmodule

// File: rtl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks on result words of the command slot tracker.
// ----------------------------------------------------------------------------
module cst_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              ok_o,
  input logic [cst_pkg::IDX_W-1:0]         slot_index_o,
  input logic [cst_pkg::MASK_W-1:0]        completed_mask_o,
  input logic [cst_pkg::MASK_W-1:0]        wake_mask_o,
  input logic                              done_res_o,
  input logic                              failed_o,
  input logic                              blocked_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped under stall");

  // a grant carries nothing else
  a_grant_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o |-> completed_mask_o == '0 && wake_mask_o == '0
                            && !done_res_o && !failed_o && !blocked_o)
    else $error("grant mixed with other results");

  // no grant, no slot index
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> slot_index_o == '0)
    else $error("slot index without grant");

  // woken slots are completed slots
  a_wake_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wake_mask_o & ~completed_mask_o) == '0)
    else $error("wake outside completed mask");

  // a blocked wait is neither done nor failed
  a_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && blocked_o |-> !done_res_o && !failed_o
                                 && completed_mask_o == '0)
    else $error("blocked wait with completion flags");

endmodule

bind command_slot_tracker cst_checker u_cst_checker (.*);

// File: bench/command_slot_tracker_chk.sv
// ----------------------------------------------------------------------------
// command_slot_tracker_chk
// Watches the command, result and configuration ports of the slot tracker.
// It keeps its own per-port copy of the issued, done, error and waiter masks
// and the slot count. It works out the result of every accepted command word
// and compares each accepted result word, field by field, with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module command_slot_tracker_chk
  import cst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SLOT_CNT_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_o,
  input  logic [1:0]            opcode_i,
  input  logic [4:0]            port_i,
  input  logic [4:0]            slot_i,
  input  logic [MASK_W-1:0]     sact_bits_i,
  input  logic [MASK_W-1:0]     ci_bits_i,
  input  logic                  task_error_i,
  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic                  ok_o,
  input  logic [IDX_W-1:0]      slot_index_o,
  input  logic [MASK_W-1:0]     completed_mask_o,
  input  logic [MASK_W-1:0]     wake_mask_o,
  input  logic                  done_res_o,
  input  logic                  failed_o,
  input  logic                  blocked_o,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PORT_N = 32;
  localparam int SLOT_N = 32;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  slot_index;
    logic [MASK_W-1:0] completed;
    logic [MASK_W-1:0] wake;
    logic              done;
    logic              failed;
    logic              blocked;
  } slot_result_t;

  // shadow copy of the per-port masks and the slot count
  logic [MASK_W-1:0]     issued_m [PORT_N];
  logic [MASK_W-1:0]     done_m   [PORT_N];
  logic [MASK_W-1:0]     err_m    [PORT_N];
  logic [MASK_W-1:0]     waiter_m [PORT_N];
  logic [SLOT_CNT_W-1:0] slot_cnt;

  slot_result_t pending_results [$];
  int           fails;

  // Apply one command word to the shadow masks and return its result.
  function automatic slot_result_t track_command(op_e op, logic [4:0] p, logic [4:0] s,
                                                 logic [MASK_W-1:0] sact,
                                                 logic [MASK_W-1:0] ci, logic tfe);
    slot_result_t      r;
    int                lim;
    logic [MASK_W-1:0] busy;
    logic [MASK_W-1:0] hit;
    r = '0;
    case (op)
      OP_RESERVE: begin
        // lowest slot clear in sact, ci and issued, below the slot count
        lim = (slot_cnt > SLOT_N) ? SLOT_N : int'(slot_cnt);
        busy = sact | ci | issued_m[p];
        for (int i = 0; i < lim; i++) begin
          if (!r.ok && !busy[i]) begin
            r.ok = 1'b1;
            r.slot_index = 5'(i);
            issued_m[p][i] = 1'b1;
            done_m[p][i] = 1'b0;
            err_m[p][i] = 1'b0;
            waiter_m[p][i] = 1'b0;
          end
        end
      end
      OP_INTR: begin
        // complete issued slots whose ci bit has dropped
        hit = issued_m[p] & ~ci;
        issued_m[p] &= ~hit;
        done_m[p] |= hit;
        err_m[p] = tfe ? (err_m[p] | hit) : (err_m[p] & ~hit);
        r.wake = waiter_m[p] & hit;
        waiter_m[p] &= ~hit;
        r.completed = hit;
        r.failed = (hit != '0) && tfe;
      end
      OP_RELEASE: begin
        // free when finished or on error, keep when still running
        if (!ci[s]) begin
          issued_m[p][s] = 1'b0;
          r.done = 1'b1;
        end else if (tfe) begin
          issued_m[p][s] = 1'b0;
          r.failed = 1'b1;
        end
      end
      default: begin
        // wait: report completion or record a waiter
        if (done_m[p][s]) begin
          r.done = 1'b1;
          r.failed = err_m[p][s];
        end else begin
          waiter_m[p][s] = 1'b1;
          r.blocked = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Track configuration, check result words, predict command words.
  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t got;
    slot_result_t want;
    logic         bad;
    if (!rst_ni) begin
      for (int i = 0; i < PORT_N; i++) begin
        issued_m[i] = '0;
        done_m[i] = '0;
        err_m[i] = '0;
        waiter_m[i] = '0;
      end
      slot_cnt = SLOT_CNT_RST;
      pending_results.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        slot_cnt = cfg_data_i;
      end

      if (out_valid_o && !out_stall_i) begin
        got = '{ok_o, slot_index_o, completed_mask_o, wake_mask_o,
                done_res_o, failed_o, blocked_o};
        if (pending_results.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: result word with no command outstanding", $realtime);
          end
          fails++;
        end else begin
          want = pending_results.pop_front();
          bad = (got.ok !== want.ok) || (got.slot_index !== want.slot_index) ||
                (got.completed !== want.completed) || (got.wake !== want.wake) ||
                (got.done !== want.done) || (got.failed !== want.failed) ||
                (got.blocked !== want.blocked);
          if (bad) begin
            if (fails < 10) begin
              $display("%0t: mismatch exp ok=%b idx=%0d comp=%h wake=%h done=%b fail=%b blk=%b",
                       $realtime, want.ok, want.slot_index, want.completed, want.wake,
                       want.done, want.failed, want.blocked);
              $display("%0t:          got ok=%b idx=%0d comp=%h wake=%h done=%b fail=%b blk=%b",
                       $realtime, got.ok, got.slot_index, got.completed, got.wake,
                       got.done, got.failed, got.blocked);
            end
            fails++;
          end
        end
      end

      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(track_command(op_e'(opcode_i), port_i, slot_i,
                                                sact_bits_i, ci_bits_i, task_error_i));
      end

      fail_count_o <= fails;
      pending_o <= pending_results.size();
    end
  end

endmodule

// File: bench/command_slot_tracker_tb.sv
// ----------------------------------------------------------------------------
// command_slot_tracker_tb
// Drives the slot tracker with a directed list of corner cases and then with
// random command words in bursts, over several slot count settings. The
// result channel stalls on a pattern of its own, with one long hold-off that
// fills the block. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module command_slot_tracker_tb;
  import cst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT_CYCLES       = 6;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int HOLD_CYCLES      = 400;
  localparam int WORDS_PER_PHASE  = 160;
  localparam int PHASE_N          = 8;
  localparam logic [SLOT_CNT_W-1:0] PHASE_COUNTS [PHASE_N] = '{
    6'd1, 6'd0, 6'd63, 6'd33, 6'd7, 6'd2, 6'd32, 6'd5
  };

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [SLOT_CNT_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            opcode = OP_RESERVE;
  logic [4:0]            port = '0;
  logic [4:0]            slot = '0;
  logic [MASK_W-1:0]     sact = '0;
  logic [MASK_W-1:0]     ci = '0;
  logic                  tfe = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  ok;
  logic [IDX_W-1:0]      slot_index;
  logic [MASK_W-1:0]     completed_mask;
  logic [MASK_W-1:0]     wake_mask;
  logic                  done_res;
  logic                  failed;
  logic                  blocked;

  int                    fail_count;
  int                    outstanding;
  int                    cycle_count = 0;
  logic                  hold_req = 1'b0;
  logic [SLOT_CNT_W-1:0] cur_count = SLOT_CNT_RST;

  command_slot_tracker uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .port_i           (port),
    .slot_i           (slot),
    .sact_bits_i      (sact),
    .ci_bits_i        (ci),
    .task_error_i     (tfe),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .ok_o             (ok),
    .slot_index_o     (slot_index),
    .completed_mask_o (completed_mask),
    .wake_mask_o      (wake_mask),
    .done_res_o       (done_res),
    .failed_o         (failed),
    .blocked_o        (blocked)
  );

  command_slot_tracker_chk chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .port_i           (port),
    .slot_i           (slot),
    .sact_bits_i      (sact),
    .ci_bits_i        (ci),
    .task_error_i     (tfe),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .ok_o             (ok),
    .slot_index_o     (slot_index),
    .completed_mask_o (completed_mask),
    .wake_mask_o      (wake_mask),
    .done_res_o       (done_res),
    .failed_o         (failed),
    .blocked_o        (blocked),
    .fail_count_o     (fail_count),
    .pending_o        (outstanding)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // end the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stall the result channel: random stretches of varying density, plus one
  // long hold-off on request so the block backs up into the command side.
  initial begin
    int   stretch;
    int   density;
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          out_stall <= 1'b1;
        end
      end
      stretch = $urandom_range(4, 60);
      case ($urandom_range(0, 3))
        0:       density = 0;
        1:       density = 20;
        2:       density = 50;
        default: density = 85;
      endcase
      repeat (stretch) begin
        @(posedge clk_i);
        out_stall <= ($urandom_range(0, 99) < density);
      end
    end
  end

  // Offer one command word and hold it until taken.
  task automatic put_word(input op_e op, input logic [4:0] p, input logic [4:0] s,
                          input logic [MASK_W-1:0] sa, input logic [MASK_W-1:0] c,
                          input logic te);
    in_valid <= 1'b1;
    opcode <= op;
    port <= p;
    slot <= s;
    sact <= sa;
    ci <= c;
    tfe <= te;
    do @(posedge clk_i); while (in_stall !== 1'b0);
  endtask

  // Drop valid and wait until every result word is back, plus the latency.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (LAT_CYCLES) @(posedge clk_i);
  endtask

  // Write the slot count while the block is idle.
  task automatic set_slot_count(input logic [SLOT_CNT_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_count = value;
  endtask

  // hardware busy bits: mostly clear, sometimes sparse, dense or full
  function automatic logic [MASK_W-1:0] busy_bits();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return '0;
    if (r < 85) return $urandom & $urandom & $urandom;
    if (r < 95) return $urandom;
    return '1;
  endfunction

  // slot mostly within the active slot count
  function automatic logic [4:0] pick_slot();
    int lim;
    lim = (cur_count > 32) ? 32 : int'(cur_count);
    if (lim == 0 || $urandom_range(0, 99) < 20) return 5'($urandom);
    return 5'($urandom_range(0, lim - 1));
  endfunction

  // Corner cases at the reset slot count.
  task automatic run_directed();
    // reserve: first slot, skip busy slots, top slot, nothing free
    put_word(OP_RESERVE, 5'd0, 5'd0, '0, '0, 1'b0);
    put_word(OP_RESERVE, 5'd0, 5'd0, 32'h0000_0001, 32'h0000_0002, 1'b0);
    put_word(OP_RESERVE, 5'd31, 5'd0, 32'h7FFF_FFFF, '0, 1'b0);
    put_word(OP_RESERVE, 5'd31, 5'd31, '1, '0, 1'b1);
    // waiter on slot 0, then interrupt with error wakes it
    put_word(OP_WAIT, 5'd0, 5'd0, '0, '0, 1'b0);
    put_word(OP_INTR, 5'd0, 5'd0, '0, 32'h0000_0004, 1'b1);
    put_word(OP_WAIT, 5'd0, 5'd0, '0, '0, 1'b0);
    // interrupt that completes nothing
    put_word(OP_INTR, 5'd7, 5'd0, '0, '0, 1'b1);
    // release while busy, then on error
    put_word(OP_RELEASE, 5'd0, 5'd2, '0, 32'h0000_0004, 1'b0);
    put_word(OP_RELEASE, 5'd0, 5'd2, '0, 32'h0000_0004, 1'b1);
    // reissue slot 0 clears its flags, release when finished keeps them
    put_word(OP_RESERVE, 5'd0, 5'd0, '0, '0, 1'b0);
    put_word(OP_WAIT, 5'd0, 5'd0, '0, '0, 1'b0);
    put_word(OP_RELEASE, 5'd0, 5'd0, '1, '0, 1'b0);
    put_word(OP_WAIT, 5'd0, 5'd0, '1, '1, 1'b1);
    // clean completion on the top port and slot
    put_word(OP_INTR, 5'd31, 5'd31, '1, '0, 1'b0);
    put_word(OP_WAIT, 5'd31, 5'd31, '0, '0, 1'b0);
    put_word(OP_RESERVE, 5'd5, 5'd0, '1, '1, 1'b0);
    put_word(OP_RESERVE, 5'd5, 5'd0, '0, 32'h8000_0000, 1'b0);
    put_word(OP_WAIT, 5'd0, 5'd31, '0, '0, 1'b0);
    put_word(OP_RELEASE, 5'd31, 5'd31, '0, '1, 1'b1);
  endtask

  // Random command words in bursts with gaps between them.
  task automatic send_random(input int count);
    int                burst;
    int                r;
    op_e               op;
    logic [4:0]        p;
    logic [4:0]        s;
    logic [MASK_W-1:0] sa;
    logic [MASK_W-1:0] c;
    logic              te;
    burst = $urandom_range(1, 12);
    for (int k = 0; k < count; k++) begin
      // focus on a few ports so the masks fill up
      p = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      s = pick_slot();
      sa = '0;
      c = '0;
      te = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: every field random
        op = op_e'($urandom_range(0, 3));
        s = 5'($urandom);
        sa = $urandom;
        c = $urandom;
        te = 1'($urandom);
      end else if (r < 43) begin
        op = OP_RESERVE;
        sa = busy_bits();
        c = busy_bits();
      end else if (r < 63) begin
        op = OP_INTR;
        c = ($urandom_range(0, 3) == 0) ? '0 : MASK_W'($urandom);
        te = ($urandom_range(0, 3) == 0);
      end else if (r < 80) begin
        op = OP_RELEASE;
        c = $urandom;
        c[s] = 1'($urandom);
        te = ($urandom_range(0, 2) == 0);
      end else begin
        op = OP_WAIT;
        sa = $urandom;
        c = $urandom;
        te = 1'($urandom);
      end
      put_word(op, p, s, sa, c, te);
      burst--;
      if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    send_random(WORDS_PER_PHASE);

    for (int ph = 0; ph < PHASE_N; ph++) begin
      set_slot_count(PHASE_COUNTS[ph]);
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      send_random(WORDS_PER_PHASE);
    end

    set_slot_count(SLOT_CNT_W'($urandom_range(3, 31)));
    send_random(WORDS_PER_PHASE);

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: command_slot_tracker.f
rtl/cst_pkg.sv
rtl/command_slot_tracker.sv
rtl/cst_checker.sv
bench/command_slot_tracker_chk.sv
bench/command_slot_tracker_tb.sv
